FILE: src/bhsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhsd_pkg
// Shared types, constants and helpers for the button history detector.
// ----------------------------------------------------------------------------
package bhsd_pkg;

  localparam int HISTORY_DEPTH   = 16;
  localparam int PLAYER_COUNT    = 4;
  localparam int MAX_CODE_LENGTH = 11;
  localparam int QUEUE_DEPTH     = 2;

  localparam int PLAYER_W        = 2;
  localparam int BUTTON_W        = 8;
  localparam int CODE_LENGTH_W   = 4;
  localparam int PATTERN_LOW_W   = 64;
  localparam int PATTERN_HIGH_W  = 24;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int PATTERN_ENTRIES = 11;
  localparam int ENTRY_INDEX_W   = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_CODE_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd2;

  localparam logic [CODE_LENGTH_W-1:0]  CODE_LENGTH_RESET  = 4'd3;
  localparam logic [PATTERN_LOW_W-1:0]  PATTERN_LOW_RESET  = 64'h0402010201408010;
  localparam logic [PATTERN_HIGH_W-1:0] PATTERN_HIGH_RESET = 24'h080804;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_RELEASE,
    KIND_PRESS
  } item_kind_t;

  typedef struct packed {
    item_kind_t            kind;
    logic [PLAYER_W-1:0]   player;
    logic [BUTTON_W-1:0]   buttons;
  } item_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE,
    BK_SCAN,
    BK_DONE
  } back_state_t;

  // pattern entry idx, newest first; entries past the last register byte read as zero
  function automatic logic [BUTTON_W-1:0] pattern_entry(
    input logic [PATTERN_LOW_W-1:0]  lo,
    input logic [PATTERN_HIGH_W-1:0] hi,
    input logic [ENTRY_INDEX_W-1:0]  idx
  );
    logic [BUTTON_W-1:0]      e;
    logic [ENTRY_INDEX_W-1:0] sel;
    e   = '0;
    sel = idx - 5'd8;
    if (idx < 5'd8) begin
      e = lo[{idx[2:0], 3'b000} +: 8];
    end else if (idx < 5'(PATTERN_ENTRIES)) begin
      e = hi[{sel[1:0], 3'b000} +: 8];
    end
    return e;
  endfunction

endpackage

FILE: src/bhsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhsd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bhsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/bhsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhsd_front
// Takes polled bytes, classifies them and hands them to the item queue.
// ----------------------------------------------------------------------------
module bhsd_front #(
  parameter int PLAYER_COUNT = bhsd_pkg::PLAYER_COUNT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              enable,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bhsd_pkg::PLAYER_W-1:0]     player,
  input  logic [bhsd_pkg::BUTTON_W-1:0]     buttons,
  output logic                              push_valid,
  input  logic                              push_ready,
  output bhsd_pkg::item_t                   push_item
);

  localparam logic [3:0] PCOUNT = 4'(PLAYER_COUNT);

  logic            hold_valid;
  bhsd_pkg::item_t hold_item;
  bhsd_pkg::item_t item_next;
  logic            accept;

  always_comb begin
    item_next.player  = player;
    item_next.buttons = buttons;
    if (4'(player) >= PCOUNT) begin
      item_next.kind = bhsd_pkg::KIND_SKIP;
    end else if (buttons == '0) begin
      item_next.kind = bhsd_pkg::KIND_RELEASE;
    end else begin
      item_next.kind = bhsd_pkg::KIND_PRESS;
    end
  end

  assign in_ready   = enable && (!hold_valid || push_ready);
  assign accept     = in_valid && in_ready;
  assign push_valid = hold_valid;
  assign push_item  = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      hold_item <= item_next;
    end
  end

endmodule

FILE: src/bhsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhsd_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module bhsd_queue #(
  parameter int DEPTH = bhsd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  bhsd_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bhsd_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  bhsd_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: src/bhsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhsd_back
// Updates per-player history and scans the newest entries against the code.
// ----------------------------------------------------------------------------
module bhsd_back #(
  parameter int HISTORY_DEPTH   = bhsd_pkg::HISTORY_DEPTH,
  parameter int PLAYER_COUNT    = bhsd_pkg::PLAYER_COUNT,
  parameter int MAX_CODE_LENGTH = bhsd_pkg::MAX_CODE_LENGTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  output logic                                  clearing,
  input  logic                                  pop_valid,
  output logic                                  pop_ready,
  input  bhsd_pkg::item_t                       pop_item,
  input  logic [bhsd_pkg::CODE_LENGTH_W-1:0]    code_length,
  input  logic [bhsd_pkg::PATTERN_LOW_W-1:0]    pattern_low,
  input  logic [bhsd_pkg::PATTERN_HIGH_W-1:0]   pattern_high,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bhsd_pkg::BUTTON_W-1:0]         held_buttons,
  output logic                                  code_entered
);

  localparam int BW      = bhsd_pkg::BUTTON_W;
  localparam int EW      = bhsd_pkg::ENTRY_INDEX_W;
  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int PIDX_W  = (PLAYER_COUNT > 1) ? $clog2(PLAYER_COUNT) : 1;
  localparam int RAM_AW  = PIDX_W + SLOT_W;
  localparam int RAM_D   = 2 ** RAM_AW;
  localparam int LEN_W   = $clog2(MAX_CODE_LENGTH + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic [RAM_AW-1:0] RAM_LAST  = RAM_AW'(RAM_D - 1);

  bhsd_pkg::back_state_t state;
  bhsd_pkg::back_state_t state_next;
  bhsd_pkg::item_t       cur;

  logic [SLOT_W-1:0] wp     [PLAYER_COUNT];
  logic              rel    [PLAYER_COUNT];
  logic [BW-1:0]     newest [PLAYER_COUNT];

  logic [RAM_AW-1:0] clr_addr;
  logic [SLOT_W-1:0] rd_slot;
  logic [LEN_W-1:0]  iss;
  logic [LEN_W-1:0]  cmp;
  logic              pend;
  logic              match;
  logic [BW-1:0]     res_held;

  logic [PIDX_W-1:0] pidx;
  logic [SLOT_W-1:0] cur_wp;
  logic              cur_rel;
  logic [BW-1:0]     cur_new;
  logic              do_write;
  logic [SLOT_W-1:0] wp_inc;
  logic [SLOT_W-1:0] slot0;
  logic [LEN_W-1:0]  len_sat;
  logic              issue;
  logic              scan_done;
  logic              load_out;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [BW-1:0]     ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  logic [BW-1:0]     ram_rdata;

  assign pidx    = PIDX_W'(cur.player);
  assign cur_wp  = wp[pidx];
  assign cur_rel = rel[pidx];
  assign cur_new = newest[pidx];
  assign wp_inc  = (cur_wp == LAST_SLOT) ? '0 : cur_wp + 1'b1;
  assign slot0   = do_write ? cur_wp : ((cur_wp == '0) ? LAST_SLOT : cur_wp - 1'b1);
  assign len_sat = (int'(code_length) > MAX_CODE_LENGTH) ? LEN_W'(MAX_CODE_LENGTH)
                                                         : LEN_W'(code_length);
  assign do_write = (state == bhsd_pkg::BK_UPDATE) && (cur.kind == bhsd_pkg::KIND_PRESS)
                    && (cur_rel || (cur.buttons != cur_new));
  assign scan_done = (state == bhsd_pkg::BK_SCAN) && (iss == len_sat) && !pend;
  assign load_out  = (state == bhsd_pkg::BK_DONE) && (!out_valid || out_ready);
  assign ram_raddr = {pidx, rd_slot};

  always_comb begin
    state_next = state;
    case (state)
      bhsd_pkg::BK_CLEAR: begin
        if (clr_addr == RAM_LAST) state_next = bhsd_pkg::BK_IDLE;
      end
      bhsd_pkg::BK_IDLE: begin
        if (pop_valid) state_next = bhsd_pkg::BK_UPDATE;
      end
      bhsd_pkg::BK_UPDATE: begin
        if (cur.kind == bhsd_pkg::KIND_SKIP) begin
          state_next = bhsd_pkg::BK_DONE;
        end else begin
          state_next = bhsd_pkg::BK_SCAN;
        end
      end
      bhsd_pkg::BK_SCAN: begin
        if (scan_done) state_next = bhsd_pkg::BK_DONE;
      end
      bhsd_pkg::BK_DONE: begin
        if (load_out) state_next = bhsd_pkg::BK_IDLE;
      end
      default: state_next = bhsd_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = 1'b0;
    pop_ready = 1'b0;
    issue     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {pidx, cur_wp};
    ram_wdata = cur.buttons;
    case (state)
      bhsd_pkg::BK_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      bhsd_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
      end
      bhsd_pkg::BK_UPDATE: begin
        ram_we = do_write;
      end
      bhsd_pkg::BK_SCAN: begin
        issue = (iss < len_sat);
      end
      bhsd_pkg::BK_DONE: begin
        issue = 1'b0;
      end
      default: begin
        clearing = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bhsd_pkg::BK_CLEAR;
      clr_addr  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < PLAYER_COUNT; i++) begin
        wp[i]     <= '0;
        rel[i]    <= 1'b0;
        newest[i] <= '0;
      end
    end else begin
      state <= state_next;
      pend  <= issue;
      if (state == bhsd_pkg::BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == bhsd_pkg::BK_UPDATE) begin
        if (cur.kind == bhsd_pkg::KIND_RELEASE) begin
          rel[pidx] <= 1'b1;
        end
        if (do_write) begin
          rel[pidx]    <= 1'b0;
          wp[pidx]     <= wp_inc;
          newest[pidx] <= cur.buttons;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end

    if (pop_valid && pop_ready) begin
      cur <= pop_item;
    end
    if (state == bhsd_pkg::BK_UPDATE) begin
      rd_slot  <= slot0;
      iss      <= '0;
      cmp      <= '0;
      match    <= (cur.kind != bhsd_pkg::KIND_SKIP);
      res_held <= (cur.kind == bhsd_pkg::KIND_PRESS) ? cur.buttons : '0;
    end else begin
      if (issue) begin
        rd_slot <= (rd_slot == '0) ? LAST_SLOT : rd_slot - 1'b1;
        iss     <= iss + 1'b1;
      end
      if (pend) begin
        match <= match
                 && (ram_rdata == bhsd_pkg::pattern_entry(pattern_low, pattern_high, EW'(cmp)));
        cmp   <= cmp + 1'b1;
      end
    end
    if (load_out) begin
      held_buttons <= res_held;
      code_entered <= match;
    end
  end

  bhsd_ram #(
    .WIDTH (BW),
    .DEPTH (RAM_D)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: src/button_history_sequence_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_history_sequence_detector
// Per-player button history rings with code sequence detection.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  in       | in_valid/in_ready  | player, buttons
//  out      | out_valid/out_ready| held_buttons, code_entered
//  cfg      | cfg_we             | cfg_index, cfg_data
//
//  The back end takes one item at a time and scans its newest L entries,
//  L = code_length capped at MAX_CODE_LENGTH; the history RAM's single read
//  port scans one entry a cycle. After reset the history RAM's 2**(player
//  bits + slot bits) entries (64 by default) are cleared, in_ready low; cfg
//  writes are taken throughout. The front register and the item queue keep
//  accepting until full while the back end works or output waits on out_ready.
// ----------------------------------------------------------------------------
module button_history_sequence_detector #(
  parameter int HISTORY_DEPTH   = bhsd_pkg::HISTORY_DEPTH,
  parameter int PLAYER_COUNT    = bhsd_pkg::PLAYER_COUNT,
  parameter int MAX_CODE_LENGTH = bhsd_pkg::MAX_CODE_LENGTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bhsd_pkg::PLAYER_W-1:0]     player,
  input  logic [bhsd_pkg::BUTTON_W-1:0]     buttons,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bhsd_pkg::BUTTON_W-1:0]     held_buttons,
  output logic                              code_entered,
  input  logic                              cfg_we,
  input  logic [bhsd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bhsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [bhsd_pkg::CODE_LENGTH_W-1:0]  code_length;
  logic [bhsd_pkg::PATTERN_LOW_W-1:0]  pattern_low;
  logic [bhsd_pkg::PATTERN_HIGH_W-1:0] pattern_high;

  logic            clearing;
  logic            push_valid;
  logic            push_ready;
  bhsd_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  bhsd_pkg::item_t pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length  <= bhsd_pkg::CODE_LENGTH_RESET;
      pattern_low  <= bhsd_pkg::PATTERN_LOW_RESET;
      pattern_high <= bhsd_pkg::PATTERN_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bhsd_pkg::REG_CODE_LENGTH:  code_length  <= cfg_data[bhsd_pkg::CODE_LENGTH_W-1:0];
        bhsd_pkg::REG_PATTERN_LOW:  pattern_low  <= cfg_data[bhsd_pkg::PATTERN_LOW_W-1:0];
        bhsd_pkg::REG_PATTERN_HIGH: pattern_high <= cfg_data[bhsd_pkg::PATTERN_HIGH_W-1:0];
        default: begin
          code_length <= code_length;
        end
      endcase
    end
  end

  bhsd_front #(
    .PLAYER_COUNT (PLAYER_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (!clearing),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .player     (player),
    .buttons    (buttons),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  bhsd_queue #(
    .DEPTH (bhsd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  bhsd_back #(
    .HISTORY_DEPTH   (HISTORY_DEPTH),
    .PLAYER_COUNT    (PLAYER_COUNT),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .clearing     (clearing),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .code_length  (code_length),
    .pattern_low  (pattern_low),
    .pattern_high (pattern_high),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .held_buttons (held_buttons),
    .code_entered (code_entered)
  );

endmodule

FILE: src/bhsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhsd_checker
// Port-level checks for the button history detector, bound to the top level.
// ----------------------------------------------------------------------------
module bhsd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bhsd_pkg::BUTTON_W-1:0] held_buttons,
  input logic                          code_entered
);

  // front register, queue, back item and output register
  localparam logic [3:0] CAPACITY = 4'(bhsd_pkg::QUEUE_DEPTH + 3);

  logic [3:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(held_buttons) && $stable(code_entered))
    else $error("result changed while stalled");

  a_clear_blocks: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("item taken during history clear");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 4'd0)
    else $error("result with no item outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= CAPACITY)
    else $error("more items in flight than storage");

endmodule

bind button_history_sequence_detector bhsd_checker u_chk (.*);

FILE: bench/tb_button_history_sequence_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_history_sequence_detector
// Self-checking bench for the per-player button history and code detector.
// Polled button bytes go in through a queue-fed driver. A behavioural copy
// of the four history rings predicts held buttons and the code flag for
// every accepted item, and a monitor compares each result in order. The run
// steps through several register settings: the reset code, an all-zero
// pattern on a fresh ring, zero, saturated and single-entry code lengths,
// all-ones and random patterns. Most items enter the configured code,
// possibly broken or with noise mixed in. Idle bursts fall on one side or
// both in most phases and on neither in the final phase.
// ----------------------------------------------------------------------------
module tb_button_history_sequence_detector;
  import bhsd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_TICKS = 32;

  typedef struct packed {
    logic [PLAYER_W-1:0] player;
    logic [BUTTON_W-1:0] buttons;
  } poll_t;

  typedef struct packed {
    logic [BUTTON_W-1:0] held;
    logic                code;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PLAYER_W-1:0]    player = '0;
  logic [BUTTON_W-1:0]    buttons = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [BUTTON_W-1:0]    held_buttons;
  logic                   code_entered;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  button_history_sequence_detector u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .player       (player),
    .buttons      (buttons),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .held_buttons (held_buttons),
    .code_entered (code_entered),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // history model
  logic [BUTTON_W-1:0]       hist [PLAYER_COUNT][HISTORY_DEPTH];
  int                        wptr [PLAYER_COUNT];
  logic                      released [PLAYER_COUNT];
  logic [CODE_LENGTH_W-1:0]  cfg_code_length = CODE_LENGTH_RESET;
  logic [PATTERN_LOW_W-1:0]  cfg_pattern_low = PATTERN_LOW_RESET;
  logic [PATTERN_HIGH_W-1:0] cfg_pattern_high = PATTERN_HIGH_RESET;

  poll_t   button_polls [$];
  report_t awaited_reports [$];
  poll_t   next_poll;
  report_t want;
  int      polls_made = 0;
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      in_idle_pct = 0;
  int      out_idle_pct = 0;
  int      in_gap = 0;
  int      out_gap = 0;

  function automatic int capped_length();
    return (int'(cfg_code_length) > MAX_CODE_LENGTH) ? MAX_CODE_LENGTH
                                                     : int'(cfg_code_length);
  endfunction

  function automatic logic [BUTTON_W-1:0] history_entry(int p, int n);
    return hist[p][(wptr[p] + 2 * HISTORY_DEPTH - 1 - n) % HISTORY_DEPTH];
  endfunction

  function automatic logic [BUTTON_W-1:0] code_byte(int i);
    logic [PATTERN_HIGH_W+PATTERN_LOW_W-1:0] pat;
    pat = {cfg_pattern_high, cfg_pattern_low};
    return pat[8*i +: 8];
  endfunction

  function automatic report_t advance_history(logic [PLAYER_W-1:0] p,
                                              logic [BUTTON_W-1:0] b);
    report_t r;
    logic    match;
    int      len;
    if (b == '0) begin
      released[p] = 1'b1;
    end else if (released[p] || b != history_entry(p, 0)) begin
      hist[p][wptr[p]] = b;
      wptr[p] = (wptr[p] + 1) % HISTORY_DEPTH;
      released[p] = 1'b0;
    end
    len = capped_length();
    match = 1'b1;
    for (int i = 0; i < len; i++) begin
      if (history_entry(p, i) != code_byte(i)) match = 1'b0;
    end
    r.held = released[p] ? '0 : history_entry(p, 0);
    r.code = match;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) awaited_reports.push_back(advance_history(player, buttons));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (button_polls.size() == 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else begin
          next_poll = button_polls.pop_front();
          in_valid <= 1'b1;
          player <= next_poll.player;
          buttons <= next_poll.buttons;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_reports.size() == 0) begin
          $error("result with no item outstanding: held_buttons %0h code_entered %0b",
                 held_buttons, code_entered);
          mismatch_count++;
        end else begin
          want = awaited_reports.pop_front();
          if (held_buttons !== want.held) begin
            $error("held_buttons: expected %0h, got %0h", want.held, held_buttons);
            mismatch_count++;
          end
          if (code_entered !== want.code) begin
            $error("code_entered: expected %0b, got %0b", want.code, code_entered);
            mismatch_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_poll(int p, logic [BUTTON_W-1:0] b);
    poll_t q;
    q.player = p[PLAYER_W-1:0];
    q.buttons = b;
    button_polls.push_back(q);
    polls_made++;
  endtask

  function automatic logic [BUTTON_W-1:0] random_button();
    return ($urandom_range(0, 1) == 0) ? BUTTON_W'(8'h01 << $urandom_range(0, 7))
                                       : BUTTON_W'($urandom_range(1, 255));
  endfunction

  // enters the current code oldest first; broken spoils one entry
  task automatic enter_code(int p, bit broken);
    int                  len;
    int                  bad;
    logic [BUTTON_W-1:0] e;
    logic [BUTTON_W-1:0] prev;
    len = capped_length();
    if (len == 0) len = $urandom_range(1, MAX_CODE_LENGTH);
    bad = broken ? $urandom_range(0, len - 1) : -1;
    prev = '0;
    add_poll(p, '0);
    for (int i = len - 1; i >= 0; i--) begin
      e = code_byte(i);
      if (i == bad) e = e ^ BUTTON_W'(8'h01 << $urandom_range(0, 7));
      if (e == prev && e != '0) add_poll(p, '0);
      if ($urandom_range(0, 7) == 0) add_poll((p + $urandom_range(1, 3)) % PLAYER_COUNT,
                                              random_button());
      add_poll(p, e);
      if ($urandom_range(0, 7) == 0) add_poll(p, e);
      prev = e;
    end
  endtask

  task automatic random_polls(int n);
    int target;
    int r;
    target = polls_made + n;
    while (polls_made < target) begin
      r = $urandom_range(0, 9);
      if (r < 6) enter_code($urandom_range(0, PLAYER_COUNT - 1), 1'b0);
      else if (r == 6) enter_code($urandom_range(0, PLAYER_COUNT - 1), 1'b1);
      else add_poll($urandom_range(0, PLAYER_COUNT - 1),
                    ($urandom_range(0, 3) == 0) ? '0 : random_button());
    end
  endtask

  task automatic settle();
    while (button_polls.size() != 0 || in_valid || awaited_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_CODE_LENGTH:  cfg_code_length = data[CODE_LENGTH_W-1:0];
      REG_PATTERN_LOW:  cfg_pattern_low = data[PATTERN_LOW_W-1:0];
      REG_PATTERN_HIGH: cfg_pattern_high = data[PATTERN_HIGH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic [CODE_LENGTH_W-1:0] len,
                                logic [PATTERN_LOW_W-1:0] lo,
                                logic [PATTERN_HIGH_W-1:0] hi);
    write_register(REG_CODE_LENGTH, CFG_DATA_W'(len));
    write_register(REG_PATTERN_LOW, CFG_DATA_W'(lo));
    write_register(REG_PATTERN_HIGH, CFG_DATA_W'(hi));
  endtask

  function automatic logic [PATTERN_LOW_W-1:0] random_low();
    logic [PATTERN_LOW_W-1:0] v;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = random_button();
    return v;
  endfunction

  function automatic logic [PATTERN_HIGH_W-1:0] random_high();
    logic [PATTERN_HIGH_W-1:0] v;
    for (int i = 0; i < 3; i++) v[8*i +: 8] = random_button();
    return v;
  endfunction

  initial begin
    for (int p = 0; p < PLAYER_COUNT; p++) begin
      wptr[p] = 0;
      released[p] = 1'b0;
      for (int s = 0; s < HISTORY_DEPTH; s++) hist[p][s] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: repeats, release and re-press, every button, short code
    in_idle_pct = 10;
    out_idle_pct = 10;
    add_poll(0, '0);
    add_poll(1, 8'hFF);
    add_poll(1, 8'hFF);
    add_poll(1, '0);
    add_poll(1, 8'hFF);
    for (int i = 0; i < BUTTON_W; i++) add_poll(2, BUTTON_W'(8'h80 >> i));
    enter_code(3, 1'b0);
    settle();

    // untouched slots compare as zero
    apply_settings(4'd11, '0, '0);
    add_poll(0, '0);
    add_poll(0, '0);
    add_poll(0, 8'h81);
    add_poll(0, '0);
    settle();

    // full-length default code
    apply_settings(4'd11, PATTERN_LOW_RESET, PATTERN_HIGH_RESET);
    in_idle_pct = 15;
    out_idle_pct = 5;
    enter_code(0, 1'b0);
    random_polls(180);
    settle();

    // empty comparison
    apply_settings(4'd0, random_low(), random_high());
    in_idle_pct = 0;
    out_idle_pct = 25;
    random_polls(100);
    settle();

    // length above the maximum saturates
    apply_settings(4'd15, random_low(), random_high());
    in_idle_pct = 20;
    out_idle_pct = 0;
    random_polls(180);
    settle();

    apply_settings(4'd1, '1, '1);
    in_idle_pct = 8;
    out_idle_pct = 8;
    random_polls(120);
    settle();

    for (int k = 0; k < 2; k++) begin
      apply_settings(CODE_LENGTH_W'($urandom_range(0, 15)), random_low(), random_high());
      in_idle_pct = $urandom_range(0, 25);
      out_idle_pct = $urandom_range(0, 25);
      random_polls(150);
      settle();
    end

    apply_settings(CODE_LENGTH_W'($urandom_range(1, MAX_CODE_LENGTH)), random_low(),
                   random_high());
    in_idle_pct = 0;
    out_idle_pct = 0;
    random_polls(100);
    settle();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/bhsd_pkg.sv
src/bhsd_ram.sv
src/bhsd_front.sv
src/bhsd_queue.sv
src/bhsd_back.sv
src/button_history_sequence_detector.sv
src/bhsd_checker.sv
bench/tb_button_history_sequence_detector.sv
